FILE: design/b64u_pkg.sv
`timescale 1ns / 1ps

package b64u_pkg;

  localparam int unsigned FifoDepth = 2;

  // position within the three-byte group
  typedef enum logic [2:0] {
    PhaseZero = 3'b001,
    PhaseOne  = 3'b010,
    PhaseTwo  = 3'b100
  } phase_e;

  // one classified byte: first sextet, optional second sextet, end-of-message mark
  typedef struct packed {
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic       has_two;
    logic       fin;
  } entry_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
    logic [6:0] ext;
    logic [6:0] res;
    ext = {1'b0, s};
    if (s < 6'd26) begin
      res = ext + 7'd65;
    end else if (s < 6'd52) begin
      res = ext + 7'd71;
    end else if (s < 6'd62) begin
      res = ext - 7'd4;
    end else if (s == 6'd62) begin
      res = 7'd45;
    end else begin
      res = 7'd95;
    end
    return res;
  endfunction

endpackage

FILE: design/base64url_encoder.sv
`timescale 1ns / 1ps
// A byte's first character passes through the queue and then the output register.
// One character per cycle leaves through the single output register while out_ready_i
//   is high; a byte yielding two characters sends them one after the other.
// A queue of FifoDepth entries between front and back absorbs output stalls.
// Reset (rst_ni low, asynchronous) clears the group phase, queue and output valid.
module base64url_encoder #(
  parameter int unsigned FifoDepth = b64u_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       final_char_o
);

  b64u_pkg::entry_t       push_entry, head;
  b64u_pkg::fifo_status_t status;
  logic                   push, pop;

  b64u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .final_byte_i (final_byte_i),
    .status_i     (status),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  b64u_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  b64u_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .status_i     (status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .final_char_o (final_char_o)
  );

endmodule

FILE: design/b64u_front.sv
`timescale 1ns / 1ps

module b64u_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              final_byte_i,
  input  b64u_pkg::fifo_status_t status_i,
  output logic              push_o,
  output b64u_pkg::entry_t  entry_o
);

  b64u_pkg::phase_e phase_q, phase_d;
  logic [3:0]       left_q, left_d;

  assign in_ready_o = !status_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    entry_o.fin = final_byte_i;
    unique case (phase_q)
      b64u_pkg::PhaseOne: begin
        entry_o.sextet0 = {left_q[1:0], in_byte_i[7:4]};
        entry_o.sextet1 = {in_byte_i[3:0], 2'b00};
        entry_o.has_two = final_byte_i;
        left_d          = in_byte_i[3:0];
        phase_d         = b64u_pkg::PhaseTwo;
      end
      b64u_pkg::PhaseTwo: begin
        entry_o.sextet0 = {left_q, in_byte_i[7:6]};
        entry_o.sextet1 = in_byte_i[5:0];
        entry_o.has_two = 1'b1;
        left_d          = 4'd0;
        phase_d         = b64u_pkg::PhaseZero;
      end
      default: begin
        entry_o.sextet0 = in_byte_i[7:2];
        entry_o.sextet1 = {in_byte_i[1:0], 4'b0000};
        entry_o.has_two = final_byte_i;
        left_d          = {2'b00, in_byte_i[1:0]};
        phase_d         = b64u_pkg::PhaseOne;
      end
    endcase
    // end of message: next byte opens a new group
    if (final_byte_i) begin
      left_d  = 4'd0;
      phase_d = b64u_pkg::PhaseZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64u_pkg::PhaseZero;
      left_q  <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

FILE: design/b64u_fifo.sv
`timescale 1ns / 1ps

module b64u_fifo #(
  parameter int unsigned Depth = b64u_pkg::FifoDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  b64u_pkg::entry_t       entry_i,
  input  logic                   pop_i,
  output b64u_pkg::entry_t       head_o,
  output b64u_pkg::fifo_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64u_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: design/b64u_back.sv
`timescale 1ns / 1ps

module b64u_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b64u_pkg::entry_t       head_i,
  input  b64u_pkg::fifo_status_t status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [6:0]             out_char_o,
  output logic                   final_char_o
);

  logic       out_valid_q, out_valid_d;
  logic [6:0] char_q, char_d;
  logic       fin_q, fin_d;
  // second character of a two-character entry, waiting for the output register
  logic       pend_q, pend_d;
  logic [5:0] pend_sextet_q;
  logic       pend_fin_q;
  logic       load_en;

  assign load_en = !out_valid_q || out_ready_i;
  assign pop_o   = load_en && !pend_q && !status_i.empty;

  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    fin_d       = fin_q;
    pend_d      = pend_q;
    if (load_en) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        char_d      = b64u_pkg::sextet_to_ascii(pend_sextet_q);
        fin_d       = pend_fin_q;
        pend_d      = 1'b0;
      end else if (!status_i.empty) begin
        out_valid_d = 1'b1;
        char_d      = b64u_pkg::sextet_to_ascii(head_i.sextet0);
        fin_d       = head_i.fin && !head_i.has_two;
        pend_d      = head_i.has_two;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    fin_q  <= fin_d;
    if (pop_o) begin
      pend_sextet_q <= head_i.sextet1;
      pend_fin_q    <= head_i.fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = char_q;
  assign final_char_o = fin_q;

endmodule

FILE: design/b64u_checker.sv
`timescale 1ns / 1ps

module b64u_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] in_byte_i,
  input logic       final_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] out_char_o,
  input logic       final_char_o
);

  // stalled output transfer holds its character and mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) && $stable(final_char_o))
    else $error("output changed while stalled");

  // stalled input transfer keeps its byte and mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i) && $stable(final_byte_i))
    else $error("input changed while stalled");

  // only alphabet characters leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_char_o >= 7'd65 && out_char_o <= 7'd90) ||
                    (out_char_o >= 7'd97 && out_char_o <= 7'd122) ||
                    (out_char_o >= 7'd48 && out_char_o <= 7'd57) ||
                    out_char_o == 7'd45 || out_char_o == 7'd95)
    else $error("character outside base64url alphabet");

  // input back-pressure only when a character is waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // nothing on the output straight after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind base64url_encoder b64u_checker u_b64u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .in_byte_i    (in_byte_i),
  .final_byte_i (final_byte_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_char_o   (out_char_o),
  .final_char_o (final_char_o)
);
